// ===== hdl/date_span_day_counter_top_defines.svh =====
// Assertion macros for the date span day counter.
`ifndef DATE_SPAN_DAY_COUNTER_TOP_DEFINES_SVH
`define DATE_SPAN_DAY_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DSDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define DSDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dsdc_pkg.sv =====
// Shared types, constants and calendar helpers for the date span day counter.
package dsdc_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 15;
  localparam int unsigned STAT_W  = 2;

  // Span limit: the smaller of the configured maximum and the field range
  localparam int unsigned MAX_SPAN  = 32767;
  localparam int unsigned FIELD_MAX = 32767;
  localparam int unsigned LIMIT     = (MAX_SPAN < FIELD_MAX) ? MAX_SPAN : FIELD_MAX;
  localparam logic [COUNT_W-1:0] LIMIT_W = COUNT_W'(LIMIT);

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ORDER    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

  // Calendar constants
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAYS_28   = 5'd28;
  localparam logic [DAY_W-1:0]   DAYS_29   = 5'd29;
  localparam logic [DAY_W-1:0]   DAYS_30   = 5'd30;
  localparam logic [DAY_W-1:0]   DAYS_31   = 5'd31;

  // Reciprocal of 25 for the century test: exact for any 14-bit year
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [14:0] RECIP_25    = 15'd20972;

  // Month length; zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                         n = leap ? DAYS_29 : DAYS_28;
      4'd4, 4'd6, 4'd9, 4'd11:      n = DAYS_30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:           n = DAYS_31;
      default:                      n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/date_span_day_counter_top.sv =====
// Date span day counter: steps a start date up to an end date, one day per cycle except at each new year entered.
//
// Input channel (in_*): start and end dates plus include_end, taken when
// in_valid is high and in_stall is low. The block holds in_stall high from
// the transfer until its result has been loaded into the output register.
// Result channel (out_*): day_count and status, held in an output register;
// out_valid stays high and the payload stays put while out_stall is high.
// Setup: capture, the leap year checks of the end year and then the start
// year, and the validity and order check; the run then steps the date a day
// at a time, with a further leap year check for each new year entered.
// Invalid dates or a reversed span finish at the check, with no stepping.
// The day stepper and the count register set the rate: at most one day per
// cycle, and a span is cut off at the limit of 32767 (about 90 year
// boundaries). The next input transfer can be taken in the cycle after a
// result is loaded. A finished result waits in its sequencer state while
// the output register still holds an untaken result.
// Reset (rst_n low at a clock edge) returns the sequencer to idle and drops
// out_valid; no item in flight survives it.
module date_span_day_counter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dsdc_pkg::DAY_W-1:0]   in_start_day,
  input  logic [dsdc_pkg::MONTH_W-1:0] in_start_month,
  input  logic [dsdc_pkg::YEAR_W-1:0]  in_start_year,
  input  logic [dsdc_pkg::DAY_W-1:0]   in_end_day,
  input  logic [dsdc_pkg::MONTH_W-1:0] in_end_month,
  input  logic [dsdc_pkg::YEAR_W-1:0]  in_end_year,
  input  logic                         in_include_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dsdc_pkg::COUNT_W-1:0] out_day_count,
  output logic [dsdc_pkg::STAT_W-1:0]  out_status
);
  import dsdc_pkg::*;

`include "date_span_day_counter_top_defines.svh"

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LEAP_E = 3'd1;
  localparam logic [2:0] S_LEAP_S = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_RUN    = 3'd4;
  localparam logic [2:0] S_LEAP_Y = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [DAY_W-1:0]   cur_d_r, cur_d_nxt;
  logic [MONTH_W-1:0] cur_m_r, cur_m_nxt;
  logic [YEAR_W-1:0]  cur_y_r, cur_y_nxt;
  logic [DAY_W-1:0]   end_d_r, end_d_nxt;
  logic [MONTH_W-1:0] end_m_r, end_m_nxt;
  logic [YEAR_W-1:0]  end_y_r, end_y_nxt;
  logic               inc_r, inc_nxt;
  logic               leap_r, leap_nxt;
  logic               leap_e_r, leap_e_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;

  logic [YEAR_W-1:0]  leap_year_in;
  logic               leap_out;
  logic [DAY_W-1:0]   cur_len;
  logic [DAY_W-1:0]   end_len;
  logic               start_ok;
  logic               end_ok;
  logic               reversed;
  logic               at_end;
  logic               out_free;
  logic [COUNT_W:0]   final_count;
  logic               in_xfer;
  logic               out_error;
  logic               out_ovf;

  // Shared leap year unit: end year first, then the running year
  assign leap_year_in = (state_r == S_LEAP_E) ? end_y_r : cur_y_r;

  dsdc_leap u_leap (
    .year (leap_year_in),
    .leap (leap_out)
  );

  // Date checks and comparisons
  assign cur_len     = month_days(cur_m_r, leap_r);
  assign end_len     = month_days(end_m_r, leap_e_r);
  assign start_ok    = (cur_len != '0) && (cur_d_r != '0) && (cur_d_r <= cur_len);
  assign end_ok      = (end_len != '0) && (end_d_r != '0) && (end_d_r <= end_len);
  assign reversed    = {end_y_r, end_m_r, end_d_r} < {cur_y_r, cur_m_r, cur_d_r};
  assign at_end      = (cur_d_r == end_d_r) && (cur_m_r == end_m_r) && (cur_y_r == end_y_r);
  assign out_free    = !out_valid_r || !out_stall;
  assign final_count = {1'b0, count_r} + (COUNT_W+1)'(inc_r);

  // Sequencer and day stepper
  always_comb begin
    state_nxt      = state_r;
    cur_d_nxt      = cur_d_r;
    cur_m_nxt      = cur_m_r;
    cur_y_nxt      = cur_y_r;
    end_d_nxt      = end_d_r;
    end_m_nxt      = end_m_r;
    end_y_nxt      = end_y_r;
    inc_nxt        = inc_r;
    leap_nxt       = leap_r;
    leap_e_nxt     = leap_e_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_d_nxt = in_start_day;
          cur_m_nxt = in_start_month;
          cur_y_nxt = in_start_year;
          end_d_nxt = in_end_day;
          end_m_nxt = in_end_month;
          end_y_nxt = in_end_year;
          inc_nxt   = in_include_end;
          state_nxt = S_LEAP_E;
        end
      end
      S_LEAP_E: begin
        leap_e_nxt = leap_out;
        state_nxt  = S_LEAP_S;
      end
      S_LEAP_S: begin
        leap_nxt  = leap_out;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        count_nxt = '0;
        if (!start_ok || !end_ok) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_count_nxt  = '0;
            out_status_nxt = STAT_INVALID;
            state_nxt      = S_IDLE;
          end
        end else if (reversed) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_count_nxt  = '0;
            out_status_nxt = STAT_ORDER;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (at_end) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            if (final_count > (COUNT_W+1)'(LIMIT_W)) begin
              out_count_nxt  = LIMIT_W;
              out_status_nxt = STAT_OVERFLOW;
            end else begin
              out_count_nxt  = final_count[COUNT_W-1:0];
              out_status_nxt = STAT_OK;
            end
            state_nxt = S_IDLE;
          end
        end else if (count_r == LIMIT_W) begin
          // at least one more day to go: the span is past the limit
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_count_nxt  = LIMIT_W;
            out_status_nxt = STAT_OVERFLOW;
            state_nxt      = S_IDLE;
          end
        end else begin
          count_nxt = count_r + 1'b1;
          if (cur_d_r < cur_len) begin
            cur_d_nxt = cur_d_r + 1'b1;
          end else if (cur_m_r < MONTH_DEC) begin
            cur_d_nxt = DAY_FIRST;
            cur_m_nxt = cur_m_r + 1'b1;
          end else begin
            cur_d_nxt = DAY_FIRST;
            cur_m_nxt = MONTH_JAN;
            cur_y_nxt = cur_y_r + 1'b1;
            state_nxt = S_LEAP_Y;
          end
        end
      end
      S_LEAP_Y: begin
        leap_nxt  = leap_out;
        state_nxt = S_RUN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cur_d_r      <= cur_d_nxt;
    cur_m_r      <= cur_m_nxt;
    cur_y_r      <= cur_y_nxt;
    end_d_r      <= end_d_nxt;
    end_m_r      <= end_m_nxt;
    end_y_r      <= end_y_nxt;
    inc_r        <= inc_nxt;
    leap_r       <= leap_nxt;
    leap_e_r     <= leap_e_nxt;
    count_r      <= count_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_day_count = out_count_r;
  assign out_status    = out_status_r;

  // Terms watched by the checks
  assign in_xfer   = in_valid && !in_stall;
  assign out_error = out_valid && (out_status == STAT_INVALID || out_status == STAT_ORDER);
  assign out_ovf   = out_valid && (out_status == STAT_OVERFLOW);

  // Checks
  `DSDC_ASSERT_NXT(a_busy_after_transfer, in_xfer, in_stall, "no stall after input transfer")
  `DSDC_ASSERT_NOW(a_error_zero_count, out_error, out_day_count == '0, "nonzero count on error")
  `DSDC_ASSERT_NOW(a_count_bounded, state_r == S_RUN, count_r <= LIMIT_W, "step count past limit")
  `DSDC_ASSERT_NOW(a_overflow_saturates, out_ovf, out_day_count == LIMIT_W, "count not saturated")

endmodule

// ===== hdl/dsdc_leap.sv =====
// Leap year unit: divisibility by 4, 16 and 25 of one 14-bit year.
module dsdc_leap (
  input  logic [dsdc_pkg::YEAR_W-1:0] year,
  output logic                        leap
);
  import dsdc_pkg::*;

  logic [YEAR_W+14:0] prod;
  logic [9:0]         quot;
  logic [YEAR_W-1:0]  quot25;
  logic [YEAR_W-1:0]  rem25;
  logic               div4;
  logic               div16;

  // year / 25 by reciprocal multiply, remainder by shift-add of 25*q
  assign prod   = (YEAR_W+15)'(year) * (YEAR_W+15)'(RECIP_25);
  assign quot   = prod[RECIP_SHIFT +: 10];
  assign quot25 = YEAR_W'({quot, 4'b0}) + YEAR_W'({quot, 3'b0}) + YEAR_W'(quot);
  assign rem25  = year - quot25;

  // Gregorian rule: by 4, and not by 100 unless by 400
  assign div4  = (year[1:0] == 2'b00);
  assign div16 = (year[3:0] == 4'b0000);
  assign leap  = div4 && ((rem25 != '0) || div16);

endmodule

// ===== sim/date_span_day_counter_top_tb.sv =====
// Testbench for date_span_day_counter_top: calendar span predictor, directed table, random dates.
module date_span_day_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsdc_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned RANDOM_ITEMS   = 75;
  localparam int unsigned IDLE_PERCENT   = 19;
  localparam int unsigned HOLD_CYCLES    = 8000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned NUM_DIRECTED   = 25;
  localparam longint unsigned TIMEOUT_CYCLES = 16_000_000;
  localparam int unsigned YEAR_MAX       = (1 << YEAR_W) - 1;

  // One date pair request as it crosses the input channel
  typedef struct packed {
    logic [DAY_W-1:0]   sd;
    logic [MONTH_W-1:0] sm;
    logic [YEAR_W-1:0]  sy;
    logic [DAY_W-1:0]   ed;
    logic [MONTH_W-1:0] em;
    logic [YEAR_W-1:0]  ey;
    logic               inc;
  } span_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  status;
  } span_result_t;

  // Directed row: known marks rows whose result is typed in here
  typedef struct packed {
    span_req_t    req;
    logic         known;
    span_result_t res;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // equal dates, with and without the end date counted
    '{'{1, 1, 2024, 1, 1, 2024, 0}, 1, '{0, STAT_OK}},
    '{'{15, 6, 2024, 15, 6, 2024, 1}, 1, '{1, STAT_OK}},
    // invalid month codes and day numbers
    '{'{1, 0, 2000, 1, 1, 2000, 0}, 1, '{0, STAT_INVALID}},
    '{'{1, 1, 2000, 1, 13, 2000, 1}, 1, '{0, STAT_INVALID}},
    '{'{31, 15, 16383, 31, 15, 16383, 1}, 1, '{0, STAT_INVALID}},
    '{'{0, 3, 2000, 1, 3, 2000, 0}, 1, '{0, STAT_INVALID}},
    '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{0, STAT_INVALID}},
    '{'{31, 4, 2023, 1, 5, 2023, 0}, 1, '{0, STAT_INVALID}},
    '{'{29, 2, 1900, 1, 3, 1900, 0}, 1, '{0, STAT_INVALID}},
    '{'{1, 2, 2000, 30, 2, 2000, 0}, 1, '{0, STAT_INVALID}},
    // leap day handling
    '{'{29, 2, 2000, 1, 3, 2000, 0}, 0, '{0, STAT_OK}},
    '{'{28, 2, 2023, 1, 3, 2023, 0}, 0, '{0, STAT_OK}},
    '{'{29, 2, 2024, 1, 3, 2024, 1}, 0, '{0, STAT_OK}},
    // end date before start date
    '{'{2, 3, 2024, 1, 3, 2024, 0}, 1, '{0, STAT_ORDER}},
    '{'{1, 1, 2025, 31, 12, 2024, 1}, 1, '{0, STAT_ORDER}},
    // year zero is a leap year
    '{'{1, 1, 0, 31, 12, 0, 1}, 0, '{0, STAT_OK}},
    '{'{28, 2, 0, 1, 3, 0, 0}, 0, '{0, STAT_OK}},
    // top of the year field and the 9999 rollover
    '{'{31, 12, 16382, 1, 1, 16383, 0}, 0, '{0, STAT_OK}},
    '{'{31, 12, 16383, 31, 12, 16383, 1}, 1, '{1, STAT_OK}},
    '{'{31, 12, 9999, 1, 1, 10000, 1}, 0, '{0, STAT_OK}},
    // spans at and past the saturation limit
    '{'{1, 1, 2000, 17, 9, 2089, 0}, 0, '{0, STAT_OK}},
    '{'{1, 1, 2000, 16, 9, 2089, 1}, 0, '{0, STAT_OK}},
    '{'{1, 1, 2000, 18, 9, 2089, 0}, 0, '{0, STAT_OK}},
    '{'{1, 1, 2000, 17, 9, 2089, 1}, 0, '{0, STAT_OK}},
    '{'{1, 1, 2000, 31, 12, 2099, 0}, 1, '{LIMIT_W, STAT_OVERFLOW}}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [DAY_W-1:0]   in_start_day;
  logic [MONTH_W-1:0] in_start_month;
  logic [YEAR_W-1:0]  in_start_year;
  logic [DAY_W-1:0]   in_end_day;
  logic [MONTH_W-1:0] in_end_month;
  logic [YEAR_W-1:0]  in_end_year;
  logic               in_include_end;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COUNT_W-1:0] out_day_count;
  logic [STAT_W-1:0]  out_status;

  // Shared knobs: written with nonblocking assignments by the stimulus and the result side
  logic quiet   = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;

  span_result_t expected_spans[$];
  int unsigned  mismatch_count = 0;

  date_span_day_counter_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_day   (in_start_day),
    .in_start_month (in_start_month),
    .in_start_year  (in_start_year),
    .in_end_day     (in_end_day),
    .in_end_month   (in_end_month),
    .in_end_year    (in_end_year),
    .in_include_end (in_include_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_day_count  (out_day_count),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Gregorian calendar predictor
  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    case (m)
      2:             return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      1, 3, 5, 7, 8, 10, 12: return 31;
      default:       return 0;
    endcase
  endfunction

  function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
    int unsigned len;
    len = month_length(m, y);
    return (len != 0) && (d >= 1) && (d <= len);
  endfunction

  // Days since the first of January of year zero
  function automatic int unsigned calendar_ordinal(int unsigned d, int unsigned m,
                                                   int unsigned y);
    int unsigned n;
    n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < m; k++) n += month_length(k, y);
    return n + d - 1;
  endfunction

  function automatic span_result_t predict_span(span_req_t r);
    span_result_t res;
    int unsigned a, b, span;
    res = '{'0, STAT_OK};
    if (!date_ok(r.sd, r.sm, r.sy) || !date_ok(r.ed, r.em, r.ey)) begin
      res.status = STAT_INVALID;
      return res;
    end
    a = calendar_ordinal(r.sd, r.sm, r.sy);
    b = calendar_ordinal(r.ed, r.em, r.ey);
    if (b < a) begin
      res.status = STAT_ORDER;
      return res;
    end
    span = b - a + r.inc;
    if (span > LIMIT) begin
      res.count  = LIMIT_W;
      res.status = STAT_OVERFLOW;
    end else begin
      res.count = COUNT_W'(span);
    end
    return res;
  endfunction

  // Mostly well-formed pairs a few years apart, some raw field noise
  function automatic span_req_t random_request();
    span_req_t   r;
    span_req_t   swapped;
    int unsigned pick;
    int unsigned step;
    pick  = $urandom_range(99);
    r.inc = 1'($urandom_range(1));
    if (pick < 15) begin
      r.sd = DAY_W'($urandom);
      r.sm = MONTH_W'($urandom);
      r.sy = YEAR_W'($urandom);
      r.ed = DAY_W'($urandom);
      r.em = MONTH_W'($urandom);
      r.ey = r.sy ^ YEAR_W'($urandom_range(3));
    end else begin
      r.sy = YEAR_W'($urandom);
      r.sm = MONTH_W'($urandom_range(1, 12));
      r.sd = DAY_W'($urandom_range(1, month_length(r.sm, r.sy)));
      pick = $urandom_range(99);
      step = (pick < 55) ? 0 : (pick < 90) ? 1 : $urandom_range(2, 8);
      r.ey = (r.sy + step > YEAR_MAX) ? YEAR_W'(YEAR_MAX) : YEAR_W'(r.sy + step);
      r.em = MONTH_W'($urandom_range(1, 12));
      r.ed = DAY_W'($urandom_range(1, month_length(r.em, r.ey)));
      // keep most reversed pairs in forward order
      if (calendar_ordinal(r.ed, r.em, r.ey) < calendar_ordinal(r.sd, r.sm, r.sy) &&
          $urandom_range(3) != 0) begin
        swapped = r;
        swapped.sd = r.ed; swapped.sm = r.em; swapped.sy = r.ey;
        swapped.ed = r.sd; swapped.em = r.sm; swapped.ey = r.sy;
        r = swapped;
      end
    end
    return r;
  endfunction

  // Present one request and hold it until the transfer
  task automatic offer_request(input span_req_t r);
    in_valid       <= 1'b1;
    in_start_day   <= r.sd;
    in_start_month <= r.sm;
    in_start_year  <= r.sy;
    in_end_day     <= r.ed;
    in_end_month   <= r.em;
    in_end_year    <= r.ey;
    in_include_end <= r.inc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random idle gap on the input side
  task automatic sender_gap();
    if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Result side: random stalls, one long hold-off, a quiet stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Compare each result transfer with the oldest expected span
  always @(posedge clk) begin : check_results
    span_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result transfer: count %0d status %0d",
                   out_day_count, out_status);
        mismatch_count++;
      end else begin
        want = expected_spans.pop_front();
        if (out_day_count !== want.count || out_status !== want.status) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("span mismatch: expected count %0d status %0d, got count %0d status %0d",
                     want.count, want.status, out_day_count, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random pairs, drain
  initial begin
    span_req_t req;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_start_day   = '0;
    in_start_month = '0;
    in_start_year  = '0;
    in_end_day     = '0;
    in_end_month   = '0;
    in_end_year    = '0;
    in_include_end = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      sender_gap();
      offer_request(DIRECTED_ROWS[i].req);
      if (DIRECTED_ROWS[i].known)
        expected_spans.push_back(DIRECTED_ROWS[i].res);
      else
        expected_spans.push_back(predict_span(DIRECTED_ROWS[i].req));
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 10) hold_go <= 1'b1;
      if (n == 40) quiet <= 1'b1;
      if (n == 70) quiet <= 1'b0;
      sender_gap();
      req = random_request();
      offer_request(req);
      expected_spans.push_back(predict_span(req));
    end
    in_valid <= 1'b0;

    while (expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_spans.size() == 0) begin
      $display("date_span_day_counter_top verification clean");
    end else begin
      $display("date_span_day_counter_top verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("date_span_day_counter_top verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dsdc_pkg.sv
hdl/dsdc_leap.sv
hdl/date_span_day_counter_top.sv
sim/date_span_day_counter_top_tb.sv
